// ===== rtl/mppt_rw_pkg.sv =====
// Shared types, codes and helpers for the random-walk MPPT charge controller.
`timescale 1ns / 1ps
`default_nettype none

package mppt_rw_pkg;

  // Default PWM resolution
  localparam int unsigned PwmBitsDef = 10;

  // Galois LFSR taps (32 31 29 1) and seed
  localparam logic [31:0] LfsrTaps = 32'hd000_0001;
  localparam logic [31:0] LfsrSeed = 32'h0000_0001;

  // Input word: packed field bits and padded tdata width
  localparam int unsigned InItemW = 75;
  localparam int unsigned InDataW = 80;

  // Output word: fixed field bits beyond the duty field
  localparam int unsigned OutFixedW = 88;

  // Measurement requests
  typedef enum logic [2:0] {
    REQ_TEMPS   = 3'd0,
    REQ_SOLAR   = 3'd1,
    REQ_CURRENT = 3'd2,
    REQ_BATTERY = 3'd3,
    REQ_PINS    = 3'd4
  } req_e;

  // Not-charging reasons
  typedef enum logic [2:0] {
    RSN_UNKNOWN     = 3'd0,
    RSN_BAT_COLD    = 3'd1,
    RSN_BAT_HOT     = 3'd2,
    RSN_CHARGER_HOT = 3'd3,
    RSN_SOLAR_LOW   = 3'd4,
    RSN_BAT_ERROR   = 3'd5
  } reason_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_BAT_TEMP_LOW  = 3'd0,
    CFG_BAT_TEMP_HIGH = 3'd1,
    CFG_CHG_TEMP_MAX  = 3'd2,
    CFG_MIN_BAT_MV    = 3'd3,
    CFG_HEADROOM_MV   = 3'd4,
    CFG_ROUND_WAIT    = 3'd5,
    CFG_SETTLE_WAIT   = 3'd6,
    CFG_DIVIDER_WAIT  = 3'd7
  } cfg_idx_e;

  // Configuration register reset values
  localparam logic signed [11:0] BatTempLowRst  = 12'sd0;
  localparam logic signed [11:0] BatTempHighRst = 12'sd450;
  localparam logic signed [11:0] ChgTempMaxRst  = 12'sd800;
  localparam logic [15:0]        MinBatMvRst    = 16'd3600;
  localparam logic [15:0]        HeadroomMvRst  = 16'd350;
  localparam logic [15:0]        RoundWaitRst   = 16'd200;
  localparam logic [15:0]        SettleWaitRst  = 16'd20;
  localparam logic [15:0]        DividerWaitRst = 16'd10;

  // Live configuration
  typedef struct packed {
    logic signed [11:0] bat_temp_min;
    logic signed [11:0] bat_temp_max;
    logic signed [11:0] chg_temp_max;
    logic [15:0]        min_bat_mv;
    logic [15:0]        headroom_mv;
    logic [15:0]        round_wait_ms;
    logic [15:0]        settle_wait_ms;
    logic [15:0]        divider_wait_ms;
  } cfg_t;

  // One input word, last field in the lowest bits
  typedef struct packed {
    logic               stat_pulled_down;
    logic               stat_pulled_up;
    logic               stat_floating;
    logic [15:0]        battery_mv;
    logic [15:0]        current_sixteenths;
    logic [15:0]        solar_mv;
    logic signed [11:0] chg_temp;
    logic signed [11:0] bat_temp;
  } in_item_t;

  // Result fields other than the duty
  typedef struct packed {
    req_e        next_request;
    logic [15:0] wait_ms;
    logic        divider_connect;
    logic        charging;
    reason_e     reason_code;
    logic [31:0] power_level;
    logic [15:0] chosen_solar_mv;
    logic [15:0] chosen_current;
  } res_t;

  // One LFSR shift
  function automatic logic [31:0] lfsr_next(input logic [31:0] r);
    lfsr_next = {1'b0, r[31:1]} ^ (r[0] ? LfsrTaps : 32'h0);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mppt_random_walk_charge_controller.sv =====
// Top level of the random-walk MPPT solar charge controller.
//
//   channel   dir   handshake                      payload
//   s_axis    in    s_axis_tvalid/s_axis_tready    measurement word (80-bit tdata)
//   m_axis    out   m_axis_tvalid/m_axis_tready    result word (PWM_BITS+88, byte padded)
//   cfg       in    cfg_we_i                       cfg_index_i, cfg_data_i
//
// Each word passes an input register, combinational logic, and a result register;
// one word per cycle is sustained while m_axis_tready stays high.
// The step from one word to the next is bound by the state update in the core.
// Reset clears the state to the start of a round, with the LFSR at one.
// A stalled result holds in the output register; one more word waits in the
// input register, after which s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module mppt_random_walk_charge_controller #(
  parameter int unsigned PWM_BITS = mppt_rw_pkg::PwmBitsDef,
  localparam int unsigned OutW = ((PWM_BITS + mppt_rw_pkg::OutFixedW + 7) / 8) * 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // bat_temp, chg_temp, solar_mv, current_sixteenths, battery_mv,
  // stat_floating, stat_pulled_up, stat_pulled_down, zero pad
  input  wire logic [mppt_rw_pkg::InDataW-1:0]   s_axis_tdata,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // duty_index, next_request, wait_ms, divider_connect, charging, reason_code,
  // power_level, chosen_solar_mv, chosen_current, zero pad
  output logic [OutW-1:0]                        m_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  input  wire logic                              cfg_we_i,
  input  wire logic [2:0]                        cfg_index_i,
  input  wire logic [15:0]                       cfg_data_i
);

  localparam int unsigned ResW = PWM_BITS + mppt_rw_pkg::OutFixedW;

  mppt_rw_pkg::cfg_t     cfg;
  mppt_rw_pkg::in_item_t in_data_q;
  logic                  in_valid_q;
  logic                  out_valid_q;
  logic [OutW-1:0]       out_data_q;
  logic                  out_load;
  logic                  in_take;
  logic [PWM_BITS-1:0]   duty;
  mppt_rw_pkg::res_t     res;
  logic [ResW-1:0]       res_word;

  // Handshake between the two register stages
  assign out_load      = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || out_load;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  mppt_rw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (out_load) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= mppt_rw_pkg::in_item_t'(s_axis_tdata[mppt_rw_pkg::InItemW-1:0]);
    end
  end

  mppt_rw_core #(.PWM_BITS(PWM_BITS)) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (out_load),
    .in_i   (in_data_q),
    .duty_o (duty),
    .res_o  (res)
  );

  // Result word, first field lowest
  assign res_word = {res.chosen_current, res.chosen_solar_mv, res.power_level,
                     res.reason_code, res.charging, res.divider_connect,
                     res.wait_ms, res.next_request, duty};

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= OutW'(res_word);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ===== rtl/mppt_rw_cfg.sv =====
// Configuration register bank for the MPPT charge controller.
`timescale 1ns / 1ps
`default_nettype none

module mppt_rw_cfg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_index_i,
  input  wire logic [15:0]       cfg_data_i,
  output mppt_rw_pkg::cfg_t      cfg_o
);

  mppt_rw_pkg::cfg_t cfg_q;

  // Register writes, no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bat_temp_min    <= mppt_rw_pkg::BatTempLowRst;
      cfg_q.bat_temp_max    <= mppt_rw_pkg::BatTempHighRst;
      cfg_q.chg_temp_max    <= mppt_rw_pkg::ChgTempMaxRst;
      cfg_q.min_bat_mv      <= mppt_rw_pkg::MinBatMvRst;
      cfg_q.headroom_mv     <= mppt_rw_pkg::HeadroomMvRst;
      cfg_q.round_wait_ms   <= mppt_rw_pkg::RoundWaitRst;
      cfg_q.settle_wait_ms  <= mppt_rw_pkg::SettleWaitRst;
      cfg_q.divider_wait_ms <= mppt_rw_pkg::DividerWaitRst;
    end else if (cfg_we_i) begin
      case (mppt_rw_pkg::cfg_idx_e'(cfg_index_i))
        mppt_rw_pkg::CFG_BAT_TEMP_LOW:  cfg_q.bat_temp_min    <= cfg_data_i[11:0];
        mppt_rw_pkg::CFG_BAT_TEMP_HIGH: cfg_q.bat_temp_max    <= cfg_data_i[11:0];
        mppt_rw_pkg::CFG_CHG_TEMP_MAX:  cfg_q.chg_temp_max    <= cfg_data_i[11:0];
        mppt_rw_pkg::CFG_MIN_BAT_MV:    cfg_q.min_bat_mv      <= cfg_data_i;
        mppt_rw_pkg::CFG_HEADROOM_MV:   cfg_q.headroom_mv     <= cfg_data_i;
        mppt_rw_pkg::CFG_ROUND_WAIT:    cfg_q.round_wait_ms   <= cfg_data_i;
        mppt_rw_pkg::CFG_SETTLE_WAIT:   cfg_q.settle_wait_ms  <= cfg_data_i;
        mppt_rw_pkg::CFG_DIVIDER_WAIT:  cfg_q.divider_wait_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/mppt_rw_draw.sv =====
// One random duty step: PWM_BITS LFSR shifts, then n*n >> PWM_BITS shaping.
`timescale 1ns / 1ps
`default_nettype none

module mppt_rw_draw #(
  parameter int unsigned PWM_BITS = mppt_rw_pkg::PwmBitsDef
) (
  input  wire logic [31:0]         lfsr_i,
  output logic      [31:0]         lfsr_o,
  output logic      [PWM_BITS-1:0] step_o
);

  logic [31:0]           r;
  logic [PWM_BITS:0]     n;
  logic [PWM_BITS-1:0]   n_sat;
  logic [2*PWM_BITS-1:0] sq;

  // Advance the LFSR, take the top bits plus one, saturate, square
  always_comb begin
    r = lfsr_i;
    for (int i = 0; i < PWM_BITS; i++) begin
      r = mppt_rw_pkg::lfsr_next(r);
    end
    n     = {1'b0, r[31 -: PWM_BITS]} + {{PWM_BITS{1'b0}}, 1'b1};
    // only all-ones top bits overflow the duty range
    n_sat = n[PWM_BITS] ? {PWM_BITS{1'b1}} : n[PWM_BITS-1:0];
    sq    = {{PWM_BITS{1'b0}}, n_sat} * {{PWM_BITS{1'b0}}, n_sat};
  end

  assign lfsr_o = r;
  assign step_o = sq[2*PWM_BITS-1:PWM_BITS];

endmodule

`default_nettype wire

// ===== rtl/mppt_rw_core.sv =====
// Measurement sequencer, perturb-and-observe decision and charge status state.
`timescale 1ns / 1ps
`default_nettype none

module mppt_rw_core #(
  parameter int unsigned PWM_BITS = mppt_rw_pkg::PwmBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mppt_rw_pkg::cfg_t    cfg_i,
  input  wire logic                 step_i,
  input  wire mppt_rw_pkg::in_item_t in_i,
  output logic [PWM_BITS-1:0]       duty_o,
  output mppt_rw_pkg::res_t         res_o
);

  typedef enum logic [2:0] {
    PH_TEMPS   = 3'd0,
    PH_SOLAR   = 3'd1,
    PH_LOWERED = 3'd2,
    PH_RAISED  = 3'd3,
    PH_BATTERY = 3'd4,
    PH_PINS    = 3'd5
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [PWM_BITS-1:0] duty_now_q, duty_now_d;
  logic [PWM_BITS-1:0] duty_before_q, duty_before_d;
  logic [PWM_BITS-1:0] duty_lowered_q, duty_lowered_d;
  logic [PWM_BITS-1:0] duty_raised_q, duty_raised_d;
  logic [31:0]         lfsr_q, lfsr_d;
  logic [15:0]         sol_before_q, sol_before_d;
  logic [15:0]         sol_lowered_q, sol_lowered_d;
  logic [15:0]         sol_raised_q, sol_raised_d;
  logic [15:0]         cur_lowered_q, cur_lowered_d;
  logic [15:0]         cur_raised_q, cur_raised_d;
  logic [31:0]         pwr_lowered_q, pwr_lowered_d;
  logic [31:0]         pwr_raised_q, pwr_raised_d;
  logic [31:0]         pwr_stored_q, pwr_stored_d;
  logic [15:0]         bat_level_q, bat_level_d;
  logic [15:0]         chosen_sol_q, chosen_sol_d;
  logic [15:0]         chosen_cur_q, chosen_cur_d;
  logic                charging_q, charging_d;
  mppt_rw_pkg::reason_e reason_q, reason_d;

  logic [31:0]         lfsr_mid, lfsr_end;
  logic [PWM_BITS-1:0] step_dec, step_inc;
  logic [PWM_BITS:0]   raise_sum;
  logic [31:0]         power;
  logic [16:0]         min_solar;
  logic [15:0]         bat_ref;
  logic                low_raised, low_lowered, low_before, low_chosen;
  logic [31:0]         pr, pl, prev;
  logic                chip_active;
  mppt_rw_pkg::req_e   req;
  logic [15:0]         wait_ms;
  logic                divider;

  // Solar voltage without enough headroom over the battery or the minimum
  function automatic logic too_low(input logic [15:0] s, input logic [15:0] bat,
                                   input logic [15:0] head, input logic [16:0] min_s);
    logic [16:0] lim_bat;
    lim_bat = {1'b0, bat} + {1'b0, head};
    too_low = ({1'b0, s} < lim_bat) || ({1'b0, s} < min_s);
  endfunction

  // Two chained draws: lowering step first, raising step second
  mppt_rw_draw #(.PWM_BITS(PWM_BITS)) u_draw_dec (
    .lfsr_i (lfsr_q),
    .lfsr_o (lfsr_mid),
    .step_o (step_dec)
  );

  mppt_rw_draw #(.PWM_BITS(PWM_BITS)) u_draw_inc (
    .lfsr_i (lfsr_mid),
    .lfsr_o (lfsr_end),
    .step_o (step_inc)
  );

  // Shared arithmetic
  assign power     = {16'd0, in_i.current_sixteenths} * {16'd0, in_i.solar_mv};
  assign raise_sum = {1'b0, duty_now_q} + {1'b0, step_inc};
  assign min_solar = {1'b0, cfg_i.min_bat_mv} + {1'b0, cfg_i.headroom_mv};
  // battery level is taken fresh in the battery phase
  assign bat_ref   = (phase_q == PH_BATTERY) ? in_i.battery_mv : bat_level_q;

  assign low_raised  = too_low(sol_raised_q, bat_ref, cfg_i.headroom_mv, min_solar);
  assign low_lowered = too_low(sol_lowered_q, bat_ref, cfg_i.headroom_mv, min_solar);
  assign low_before  = too_low(sol_before_q, bat_ref, cfg_i.headroom_mv, min_solar);
  assign low_chosen  = too_low(chosen_sol_q, bat_ref, cfg_i.headroom_mv, min_solar);

  assign pr   = low_raised  ? 32'd0 : pwr_raised_q;
  assign pl   = low_lowered ? 32'd0 : pwr_lowered_q;
  assign prev = low_before  ? 32'd0 : pwr_stored_q;

  assign chip_active = !(!in_i.stat_pulled_down && in_i.stat_pulled_up);

  // Next state for the phase of this word
  always_comb begin
    phase_d        = phase_q;
    duty_now_d     = duty_now_q;
    duty_before_d  = duty_before_q;
    duty_lowered_d = duty_lowered_q;
    duty_raised_d  = duty_raised_q;
    lfsr_d         = lfsr_q;
    sol_before_d   = sol_before_q;
    sol_lowered_d  = sol_lowered_q;
    sol_raised_d   = sol_raised_q;
    cur_lowered_d  = cur_lowered_q;
    cur_raised_d   = cur_raised_q;
    pwr_lowered_d  = pwr_lowered_q;
    pwr_raised_d   = pwr_raised_q;
    pwr_stored_d   = pwr_stored_q;
    bat_level_d    = bat_level_q;
    chosen_sol_d   = chosen_sol_q;
    chosen_cur_d   = chosen_cur_q;
    charging_d     = charging_q;
    reason_d       = reason_q;
    req            = mppt_rw_pkg::REQ_TEMPS;
    wait_ms        = cfg_i.round_wait_ms;
    divider        = 1'b0;

    case (phase_q)
      PH_SOLAR: begin
        sol_before_d   = in_i.solar_mv;
        duty_before_d  = duty_now_q;
        lfsr_d         = lfsr_end;
        duty_lowered_d = (step_dec > duty_now_q) ? '0 : duty_now_q - step_dec;
        duty_raised_d  = raise_sum[PWM_BITS] ? {PWM_BITS{1'b1}} : raise_sum[PWM_BITS-1:0];
        duty_now_d     = duty_lowered_d;
        phase_d        = PH_LOWERED;
        req            = mppt_rw_pkg::REQ_CURRENT;
        wait_ms        = cfg_i.settle_wait_ms;
      end
      PH_LOWERED: begin
        cur_lowered_d = in_i.current_sixteenths;
        sol_lowered_d = in_i.solar_mv;
        pwr_lowered_d = power;
        duty_now_d    = duty_raised_q;
        phase_d       = PH_RAISED;
        req           = mppt_rw_pkg::REQ_CURRENT;
        wait_ms       = cfg_i.settle_wait_ms;
      end
      PH_RAISED: begin
        cur_raised_d = in_i.current_sixteenths;
        sol_raised_d = in_i.solar_mv;
        pwr_raised_d = power;
        phase_d      = PH_BATTERY;
        req          = mppt_rw_pkg::REQ_BATTERY;
        wait_ms      = cfg_i.divider_wait_ms;
        divider      = 1'b1;
      end
      PH_BATTERY: begin
        bat_level_d   = in_i.battery_mv;
        pwr_raised_d  = pr;
        pwr_lowered_d = pl;
        if (pr > prev) begin
          duty_now_d   = duty_raised_q;
          chosen_cur_d = cur_raised_q;
          chosen_sol_d = sol_raised_q;
          pwr_stored_d = pr;
        end else if (pl > prev) begin
          duty_now_d   = duty_lowered_q;
          chosen_cur_d = cur_lowered_q;
          chosen_sol_d = sol_lowered_q;
          pwr_stored_d = pl;
        end else begin
          // no trial wins: back to the old point
          duty_now_d   = duty_before_q;
          chosen_sol_d = sol_before_q;
          pwr_stored_d = prev;
        end
        phase_d = PH_PINS;
        req     = mppt_rw_pkg::REQ_PINS;
        wait_ms = cfg_i.settle_wait_ms;
      end
      PH_PINS: begin
        if (({1'b0, chosen_sol_q} >= min_solar) && chip_active) begin
          charging_d = 1'b1;
          reason_d   = mppt_rw_pkg::RSN_UNKNOWN;
        end else begin
          charging_d = 1'b0;
          if (bat_level_q < cfg_i.min_bat_mv) begin
            reason_d = mppt_rw_pkg::RSN_BAT_ERROR;
          end else if (low_chosen) begin
            reason_d = mppt_rw_pkg::RSN_SOLAR_LOW;
          end else begin
            reason_d = mppt_rw_pkg::RSN_UNKNOWN;
          end
        end
        phase_d = PH_TEMPS;
      end
      default: begin
        // temperature check, also taken for an undefined phase code
        if (in_i.bat_temp < cfg_i.bat_temp_min) begin
          reason_d   = mppt_rw_pkg::RSN_BAT_COLD;
          charging_d = 1'b0;
          duty_now_d = '0;
          phase_d    = PH_TEMPS;
        end else if (in_i.bat_temp > cfg_i.bat_temp_max) begin
          reason_d   = mppt_rw_pkg::RSN_BAT_HOT;
          charging_d = 1'b0;
          duty_now_d = '0;
          phase_d    = PH_TEMPS;
        end else if (in_i.chg_temp > cfg_i.chg_temp_max) begin
          reason_d   = mppt_rw_pkg::RSN_CHARGER_HOT;
          charging_d = 1'b0;
          duty_now_d = '0;
          phase_d    = PH_TEMPS;
        end else begin
          phase_d = PH_SOLAR;
          req     = mppt_rw_pkg::REQ_SOLAR;
          wait_ms = '0;
        end
      end
    endcase
  end

  // State update, one word per step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_TEMPS;
      duty_now_q     <= '0;
      duty_before_q  <= '0;
      duty_lowered_q <= '0;
      duty_raised_q  <= '0;
      lfsr_q         <= mppt_rw_pkg::LfsrSeed;
      sol_before_q   <= '0;
      sol_lowered_q  <= '0;
      sol_raised_q   <= '0;
      cur_lowered_q  <= '0;
      cur_raised_q   <= '0;
      pwr_lowered_q  <= '0;
      pwr_raised_q   <= '0;
      pwr_stored_q   <= '0;
      bat_level_q    <= '0;
      chosen_sol_q   <= '0;
      chosen_cur_q   <= '0;
      charging_q     <= 1'b0;
      reason_q       <= mppt_rw_pkg::RSN_UNKNOWN;
    end else if (step_i) begin
      phase_q        <= phase_d;
      duty_now_q     <= duty_now_d;
      duty_before_q  <= duty_before_d;
      duty_lowered_q <= duty_lowered_d;
      duty_raised_q  <= duty_raised_d;
      lfsr_q         <= lfsr_d;
      sol_before_q   <= sol_before_d;
      sol_lowered_q  <= sol_lowered_d;
      sol_raised_q   <= sol_raised_d;
      cur_lowered_q  <= cur_lowered_d;
      cur_raised_q   <= cur_raised_d;
      pwr_lowered_q  <= pwr_lowered_d;
      pwr_raised_q   <= pwr_raised_d;
      pwr_stored_q   <= pwr_stored_d;
      bat_level_q    <= bat_level_d;
      chosen_sol_q   <= chosen_sol_d;
      chosen_cur_q   <= chosen_cur_d;
      charging_q     <= charging_d;
      reason_q       <= reason_d;
    end
  end

  // Result reflects the state after this word
  assign duty_o                = duty_now_d;
  assign res_o.next_request    = req;
  assign res_o.wait_ms         = wait_ms;
  assign res_o.divider_connect = divider;
  assign res_o.charging        = charging_d;
  assign res_o.reason_code     = reason_d;
  assign res_o.power_level     = pwr_stored_d;
  assign res_o.chosen_solar_mv = chosen_sol_d;
  assign res_o.chosen_current  = chosen_cur_d;

endmodule

`default_nettype wire

// ===== rtl/mppt_rw_checker.sv =====
// Port-level checks for the MPPT charge controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mppt_rw_checker #(
  parameter int unsigned PWM_BITS = mppt_rw_pkg::PwmBitsDef,
  localparam int unsigned OutW = ((PWM_BITS + mppt_rw_pkg::OutFixedW + 7) / 8) * 8
) (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            m_axis_tvalid,
  input wire logic            m_axis_tready,
  input wire logic [OutW-1:0] m_axis_tdata
);

  logic [2:0]  req;
  logic [15:0] wait_ms;
  logic        divider;
  logic        charging;
  logic [2:0]  reason;

  assign req      = m_axis_tdata[PWM_BITS +: 3];
  assign wait_ms  = m_axis_tdata[PWM_BITS + 3 +: 16];
  assign divider  = m_axis_tdata[PWM_BITS + 19];
  assign charging = m_axis_tdata[PWM_BITS + 20];
  assign reason   = m_axis_tdata[PWM_BITS + 21 +: 3];

  // Stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // Divider only while asking for the battery voltage
  a_divider: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && divider |-> req == mppt_rw_pkg::REQ_BATTERY)
    else $error("divider connected outside battery request");

  // Charging carries no fault reason
  a_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && charging |-> reason == mppt_rw_pkg::RSN_UNKNOWN)
    else $error("charging with a reason set");

  // Solar request follows a clean temperature check at once
  a_solar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && req == mppt_rw_pkg::REQ_SOLAR |-> wait_ms == 16'd0 && !divider)
    else $error("solar request with wait or divider");

endmodule

bind mppt_random_walk_charge_controller mppt_rw_checker #(.PWM_BITS(PWM_BITS)) u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the random-walk MPPT charge controller.
`timescale 1ns / 1ps

module testbench;

  localparam int PWM_W = 10;
  localparam int DUTY_TOP = (1 << PWM_W) - 1;
  localparam logic [31:0] LFSR_POLY = 32'hd000_0001;
  localparam int RES_W = ((PWM_W + mppt_rw_pkg::OutFixedW + 7) / 8) * 8;
  localparam int PAD_W = mppt_rw_pkg::InDataW - mppt_rw_pkg::InItemW;

  // Which measurement the controller is waiting for
  typedef enum logic [2:0] {
    AWAIT_TEMPS,
    AWAIT_SOLAR,
    AWAIT_LOWERED,
    AWAIT_RAISED,
    AWAIT_BATTERY,
    AWAIT_PINS
  } round_step_e;

  // One expected result word, unpacked
  typedef struct packed {
    logic [PWM_W-1:0]     duty;
    mppt_rw_pkg::req_e    req;
    logic [15:0]          wait_ms;
    logic                 divider;
    logic                 charging;
    mppt_rw_pkg::reason_e reason;
    logic [31:0]          power;
    logic [15:0]          solar;
    logic [15:0]          current;
  } report_t;

  // Tracks the controller's round, predicts each result word and checks it
  class charge_round_tracker;
    logic signed [11:0] bat_temp_min = mppt_rw_pkg::BatTempLowRst;
    logic signed [11:0] bat_temp_max = mppt_rw_pkg::BatTempHighRst;
    logic signed [11:0] chg_temp_max = mppt_rw_pkg::ChgTempMaxRst;
    logic [15:0] min_bat_mv = mppt_rw_pkg::MinBatMvRst;
    logic [15:0] headroom_mv = mppt_rw_pkg::HeadroomMvRst;
    logic [15:0] round_wait_ms = mppt_rw_pkg::RoundWaitRst;
    logic [15:0] settle_wait_ms = mppt_rw_pkg::SettleWaitRst;
    logic [15:0] divider_wait_ms = mppt_rw_pkg::DividerWaitRst;

    round_step_e step = AWAIT_TEMPS;
    int duty_now = 0, duty_before = 0, duty_lowered = 0, duty_raised = 0;
    logic [31:0] lfsr = 32'h1;
    logic [15:0] solar_before = '0, solar_lowered = '0, solar_raised = '0;
    logic [15:0] current_lowered = '0, current_raised = '0;
    logic [31:0] power_lowered = '0, power_raised = '0, power_stored = '0;
    logic [15:0] battery_level = '0, chosen_solar = '0, chosen_current = '0;
    logic charging = 1'b0;
    mppt_rw_pkg::reason_e reason = mppt_rw_pkg::RSN_UNKNOWN;

    report_t due_reports[$];
    int mismatches = 0;

    function void set_reg(mppt_rw_pkg::cfg_idx_e idx, logic [15:0] v);
      case (idx)
        mppt_rw_pkg::CFG_BAT_TEMP_LOW:  bat_temp_min = v[11:0];
        mppt_rw_pkg::CFG_BAT_TEMP_HIGH: bat_temp_max = v[11:0];
        mppt_rw_pkg::CFG_CHG_TEMP_MAX:  chg_temp_max = v[11:0];
        mppt_rw_pkg::CFG_MIN_BAT_MV:    min_bat_mv = v;
        mppt_rw_pkg::CFG_HEADROOM_MV:   headroom_mv = v;
        mppt_rw_pkg::CFG_ROUND_WAIT:    round_wait_ms = v;
        mppt_rw_pkg::CFG_SETTLE_WAIT:   settle_wait_ms = v;
        default:                        divider_wait_ms = v;
      endcase
    endfunction

    // PWM_W LFSR shifts, then the top bits plus one, saturated, squared and scaled
    function int draw_step();
      int n;
      for (int i = 0; i < PWM_W; i++)
        lfsr = {1'b0, lfsr[31:1]} ^ (lfsr[0] ? LFSR_POLY : 32'h0);
      n = int'(lfsr >> (32 - PWM_W)) + 1;
      if (n > DUTY_TOP) n = DUTY_TOP;
      return (n * n) >> PWM_W;
    endfunction

    function int clamp_duty(int d);
      if (d < 0) return 0;
      if (d > DUTY_TOP) return DUTY_TOP;
      return d;
    endfunction

    // Solar voltage without enough headroom over battery or minimum
    function bit solar_short(logic [15:0] s);
      return int'(s) < int'(battery_level) + int'(headroom_mv) ||
             int'(s) < int'(min_bat_mv) + int'(headroom_mv);
    endfunction

    function void take_measurement(mppt_rw_pkg::in_item_t it);
      report_t r;
      logic [31:0] prev;
      bit chip_on;
      bit faulted;
      r.req = mppt_rw_pkg::REQ_TEMPS;
      r.wait_ms = round_wait_ms;
      r.divider = 1'b0;
      case (step)
        AWAIT_SOLAR: begin
          solar_before = it.solar_mv;
          duty_before = duty_now;
          // lowering step is drawn first
          duty_lowered = clamp_duty(duty_before - draw_step());
          duty_raised = clamp_duty(duty_before + draw_step());
          duty_now = duty_lowered;
          step = AWAIT_LOWERED;
          r.req = mppt_rw_pkg::REQ_CURRENT;
          r.wait_ms = settle_wait_ms;
        end
        AWAIT_LOWERED: begin
          current_lowered = it.current_sixteenths;
          solar_lowered = it.solar_mv;
          power_lowered = 32'(it.current_sixteenths) * 32'(it.solar_mv);
          duty_now = duty_raised;
          step = AWAIT_RAISED;
          r.req = mppt_rw_pkg::REQ_CURRENT;
          r.wait_ms = settle_wait_ms;
        end
        AWAIT_RAISED: begin
          current_raised = it.current_sixteenths;
          solar_raised = it.solar_mv;
          power_raised = 32'(it.current_sixteenths) * 32'(it.solar_mv);
          step = AWAIT_BATTERY;
          r.req = mppt_rw_pkg::REQ_BATTERY;
          r.wait_ms = divider_wait_ms;
          r.divider = 1'b1;
        end
        AWAIT_BATTERY: begin
          prev = power_stored;
          battery_level = it.battery_mv;
          if (solar_short(solar_raised)) power_raised = '0;
          if (solar_short(solar_lowered)) power_lowered = '0;
          if (solar_short(solar_before)) prev = '0;
          // raised point wins ties against lowered
          if (power_raised > prev) begin
            duty_now = duty_raised;
            chosen_current = current_raised;
            chosen_solar = solar_raised;
            power_stored = power_raised;
          end else if (power_lowered > prev) begin
            duty_now = duty_lowered;
            chosen_current = current_lowered;
            chosen_solar = solar_lowered;
            power_stored = power_lowered;
          end else begin
            duty_now = duty_before;
            chosen_solar = solar_before;
            power_stored = prev;
          end
          step = AWAIT_PINS;
          r.req = mppt_rw_pkg::REQ_PINS;
          r.wait_ms = settle_wait_ms;
        end
        AWAIT_PINS: begin
          // only pulled-up high with pulled-down low means the charger is off
          chip_on = !(it.stat_pulled_up && !it.stat_pulled_down);
          if (int'(chosen_solar) >= int'(min_bat_mv) + int'(headroom_mv) && chip_on) begin
            charging = 1'b1;
            reason = mppt_rw_pkg::RSN_UNKNOWN;
          end else begin
            charging = 1'b0;
            if (battery_level < min_bat_mv) reason = mppt_rw_pkg::RSN_BAT_ERROR;
            else if (solar_short(chosen_solar)) reason = mppt_rw_pkg::RSN_SOLAR_LOW;
            else reason = mppt_rw_pkg::RSN_UNKNOWN;
          end
          step = AWAIT_TEMPS;
        end
        default: begin
          faulted = 1'b1;
          if (it.bat_temp < bat_temp_min) reason = mppt_rw_pkg::RSN_BAT_COLD;
          else if (it.bat_temp > bat_temp_max) reason = mppt_rw_pkg::RSN_BAT_HOT;
          else if (it.chg_temp > chg_temp_max) reason = mppt_rw_pkg::RSN_CHARGER_HOT;
          else faulted = 1'b0;
          if (faulted) begin
            charging = 1'b0;
            duty_now = 0;
          end else begin
            step = AWAIT_SOLAR;
            r.req = mppt_rw_pkg::REQ_SOLAR;
            r.wait_ms = '0;
          end
        end
      endcase
      r.duty = duty_now[PWM_W-1:0];
      r.charging = charging;
      r.reason = reason;
      r.power = power_stored;
      r.solar = chosen_solar;
      r.current = chosen_current;
      due_reports.push_back(r);
    endfunction

    function void compare(string field, longint unsigned want, longint unsigned got);
      if (want == got) return;
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %0d got %0d", $time, field, want, got);
    endfunction

    function void check_report(logic [RES_W-1:0] d);
      report_t e;
      if (due_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result word with none expected: %h", $time, d);
        return;
      end
      e = due_reports.pop_front();
      compare("duty_index", e.duty, d[9:0]);
      compare("next_request", e.req, d[12:10]);
      compare("wait_ms", e.wait_ms, d[28:13]);
      compare("divider_connect", e.divider, d[29]);
      compare("charging", e.charging, d[30]);
      compare("reason_code", e.reason, d[33:31]);
      compare("power_level", e.power, d[65:34]);
      compare("chosen_solar_mv", e.solar, d[81:66]);
      compare("chosen_current", e.current, d[97:82]);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic [mppt_rw_pkg::InDataW-1:0] s_axis_tdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [RES_W-1:0] m_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  charge_round_tracker tracker;

  mppt_random_walk_charge_controller u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Receiver backpressure
  always @(negedge clk_i) begin
    m_axis_tready <= (int'($urandom_range(99)) >= rx_idle_pct);
  end

  // Result word monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) tracker.check_report(m_axis_tdata);
  end

  function automatic mppt_rw_pkg::in_item_t meas(int bt, int ct, int sv, int cur, int bat,
                                                 logic [2:0] pins);
    mppt_rw_pkg::in_item_t it;
    it.bat_temp = 12'(bt);
    it.chg_temp = 12'(ct);
    it.solar_mv = 16'(sv);
    it.current_sixteenths = 16'(cur);
    it.battery_mv = 16'(bat);
    {it.stat_pulled_down, it.stat_pulled_up, it.stat_floating} = pins;
    return it;
  endfunction

  function automatic int mv_clip(int v);
    return (v < 0) ? 0 : (v > 65535) ? 65535 : v;
  endfunction

  // Random word shaped for the measurement the controller waits for
  function automatic mppt_rw_pkg::in_item_t random_measurement();
    logic [95:0] raw;
    mppt_rw_pkg::in_item_t it;
    int lo, hi, cmax, floor_mv;
    raw = {$urandom, $urandom, $urandom};
    it = raw[mppt_rw_pkg::InItemW-1:0];
    if ($urandom_range(9) == 0) return it;
    case (tracker.step)
      AWAIT_TEMPS: begin
        lo = tracker.bat_temp_min;
        hi = tracker.bat_temp_max;
        cmax = tracker.chg_temp_max;
        // now and then just outside the limits
        if ($urandom_range(5) == 0) begin
          lo -= 20;
          hi += 20;
          cmax += 20;
        end
        if (lo <= hi) it.bat_temp = 12'(lo + int'($urandom_range(hi - lo)));
        if (cmax >= -400) it.chg_temp = 12'(-400 + int'($urandom_range(cmax + 400)));
      end
      AWAIT_SOLAR, AWAIT_LOWERED, AWAIT_RAISED: begin
        floor_mv = (tracker.battery_level > tracker.min_bat_mv) ?
                   int'(tracker.battery_level) : int'(tracker.min_bat_mv);
        floor_mv += int'(tracker.headroom_mv);
        it.solar_mv = 16'(mv_clip(floor_mv - 300 + int'($urandom_range(4000))));
        if ($urandom_range(7) != 0) it.current_sixteenths = 16'($urandom_range(4095));
      end
      AWAIT_BATTERY: begin
        it.battery_mv = 16'(mv_clip(int'(tracker.min_bat_mv) - 300 +
                                    int'($urandom_range(900))));
      end
      default: ;
    endcase
    return it;
  endfunction

  // Present one measurement word and wait for it to be taken
  task automatic send_measurement(mppt_rw_pkg::in_item_t it);
    @(negedge clk_i);
    while (int'($urandom_range(99)) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{PAD_W{1'b0}}, it};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tracker.take_measurement(it);
  endtask

  task automatic pause_until_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tracker.due_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(mppt_rw_pkg::cfg_idx_e idx, int v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= 16'(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_reg(idx, 16'(v));
  endtask

  task automatic apply_setting(int s);
    case (s)
      1: begin
        // widest temperature window, no voltage floor
        write_reg(mppt_rw_pkg::CFG_BAT_TEMP_LOW, -400);
        write_reg(mppt_rw_pkg::CFG_BAT_TEMP_HIGH, 1250);
        write_reg(mppt_rw_pkg::CFG_CHG_TEMP_MAX, 1250);
        write_reg(mppt_rw_pkg::CFG_MIN_BAT_MV, 0);
        write_reg(mppt_rw_pkg::CFG_HEADROOM_MV, 0);
        write_reg(mppt_rw_pkg::CFG_ROUND_WAIT, 65535);
        write_reg(mppt_rw_pkg::CFG_SETTLE_WAIT, 0);
        write_reg(mppt_rw_pkg::CFG_DIVIDER_WAIT, 65535);
      end
      2: begin
        // floor beyond any 16-bit voltage, charger limit at the bottom
        write_reg(mppt_rw_pkg::CFG_CHG_TEMP_MAX, -400);
        write_reg(mppt_rw_pkg::CFG_MIN_BAT_MV, 65535);
        write_reg(mppt_rw_pkg::CFG_HEADROOM_MV, 65535);
        write_reg(mppt_rw_pkg::CFG_ROUND_WAIT, 0);
        write_reg(mppt_rw_pkg::CFG_SETTLE_WAIT, 65535);
        write_reg(mppt_rw_pkg::CFG_DIVIDER_WAIT, 0);
      end
      3: begin
        // single legal battery temperature
        write_reg(mppt_rw_pkg::CFG_BAT_TEMP_LOW, 450);
        write_reg(mppt_rw_pkg::CFG_BAT_TEMP_HIGH, 450);
        write_reg(mppt_rw_pkg::CFG_CHG_TEMP_MAX, 0);
        write_reg(mppt_rw_pkg::CFG_MIN_BAT_MV, int'($urandom_range(2000, 12000)));
        write_reg(mppt_rw_pkg::CFG_HEADROOM_MV, int'($urandom_range(2000)));
        write_reg(mppt_rw_pkg::CFG_ROUND_WAIT, int'($urandom_range(65535)));
      end
      default: begin
        write_reg(mppt_rw_pkg::CFG_BAT_TEMP_LOW, -100 + int'($urandom_range(100)));
        write_reg(mppt_rw_pkg::CFG_BAT_TEMP_HIGH, 300 + int'($urandom_range(400)));
        write_reg(mppt_rw_pkg::CFG_CHG_TEMP_MAX, 500 + int'($urandom_range(700)));
        write_reg(mppt_rw_pkg::CFG_MIN_BAT_MV, int'($urandom_range(3000, 4200)));
        write_reg(mppt_rw_pkg::CFG_HEADROOM_MV, int'($urandom_range(100, 600)));
        write_reg(mppt_rw_pkg::CFG_ROUND_WAIT, int'($urandom_range(65535)));
        write_reg(mppt_rw_pkg::CFG_SETTLE_WAIT, int'($urandom_range(65535)));
        write_reg(mppt_rw_pkg::CFG_DIVIDER_WAIT, int'($urandom_range(65535)));
      end
    endcase
  endtask

  task automatic run_random(int count);
    for (int k = 0; k < count; k++) begin
      if (k == count / 2) pause_until_drained();
      send_measurement(random_measurement());
    end
  endtask

  // Run limit
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    tracker = new;
    tx_idle_pct = 21;
    rx_idle_pct = 85;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rounds at reset configuration: each temperature fault first
    send_measurement(meas(-400, 0, 0, 0, 0, 3'b000));
    send_measurement(meas(1250, 0, 0, 0, 0, 3'b000));
    send_measurement(meas(200, 1250, 0, 0, 0, 3'b000));
    send_measurement(meas(2047, 2047, 65535, 65535, 65535, 3'b111));
    // limits exactly met; lowered point wins, charger on
    send_measurement(meas(0, 800, 0, 0, 0, 3'b000));
    send_measurement(meas(0, 0, 4000, 0, 0, 3'b000));
    send_measurement(meas(0, 0, 65535, 65535, 0, 3'b000));
    send_measurement(meas(0, 0, 0, 0, 0, 3'b000));
    send_measurement(meas(0, 0, 0, 0, 3700, 3'b000));
    send_measurement(meas(0, 0, 0, 0, 0, 3'b100));
    // raised point wins over a zeroed previous power; battery error
    send_measurement(meas(450, -400, 0, 0, 0, 3'b000));
    send_measurement(meas(0, 0, 3000, 0, 0, 3'b000));
    send_measurement(meas(0, 0, 3900, 500, 0, 3'b000));
    send_measurement(meas(0, 0, 4100, 600, 0, 3'b000));
    send_measurement(meas(0, 0, 0, 0, 3000, 3'b000));
    send_measurement(meas(0, 0, 0, 0, 0, 3'b011));
    // no point wins, solar low
    send_measurement(meas(100, 100, 0, 0, 0, 3'b000));
    send_measurement(meas(0, 0, 0, 0, 0, 3'b000));
    send_measurement(meas(0, 0, 0, 0, 0, 3'b000));
    send_measurement(meas(0, 0, 0, 0, 0, 3'b000));
    send_measurement(meas(0, 0, 0, 0, 65535, 3'b000));
    send_measurement(meas(0, 0, 0, 0, 0, 3'b110));

    // Random rounds under several settings and idle profiles
    for (int s = 1; s <= 4; s++) begin
      pause_until_drained();
      repeat (2) @(posedge clk_i);
      apply_setting(s);
      if (s == 1) begin
        tx_idle_pct = 21;
        rx_idle_pct = 85;
      end else if (s == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = 85;
        rx_idle_pct = 21;
      end
      run_random((s == 2) ? 50 : (s == 3) ? 90 : 130);
    end

    pause_until_drained();
    repeat (10) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.due_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
